// ===== rtl/sstf_pkg.sv =====
// shared constants, types and helper functions for the sstf disk scheduler
// no dependencies; used by the interfaces, the cell and the top level
package sstf_pkg;

	localparam int MAX_REQUESTS = 1024;
	localparam int TRACK_BITS   = 12;

	localparam int CELLS        = (MAX_REQUESTS >= 4) ? 4 : 2;
	localparam int CELL_W       = $clog2(CELLS);
	localparam int BANK_DEPTH   = (MAX_REQUESTS + CELLS - 1) / CELLS;
	localparam int ROW_W        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int IDX_W        = ROW_W + CELL_W;
	localparam int CMP_W        = IDX_W + 1;
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int DRAIN_CYCLES = CELLS + 4;
	localparam int DRN_W        = $clog2(DRAIN_CYCLES);

	localparam int OP_W         = 2;
	localparam int ST_W         = 2;
	localparam int OUT_TRK_W    = 12;
	localparam int OUT_IDX_W    = 10;
	localparam int SUM_W        = 22;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_SERVE = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_SERVED = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic                  served;
		logic [TRACK_BITS-1:0] track;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                  valid;
		logic [TRACK_BITS-1:0] seek;
		logic [IDX_W-1:0]      idx;
		logic [TRACK_BITS-1:0] track;
	} best_t;

	typedef struct packed {
		logic             scan;
		logic             clear_best;
		logic [ROW_W-1:0] row;
	} scan_ctrl_t;

	typedef struct packed {
		logic              en;
		logic [CELL_W-1:0] bank;
		logic [ROW_W-1:0]  row;
		entry_t            entry;
	} wr_req_t;

	function automatic logic [TRACK_BITS-1:0] seek_dist(
		logic [TRACK_BITS-1:0] t,
		logic [TRACK_BITS-1:0] h
	);
		return (t >= h) ? (t - h) : (h - t);
	endfunction

	// closer wins, lower table index breaks a tie
	function automatic best_t pick_best(best_t a, best_t b);
		logic a_wins;
		a_wins = a.valid && (!b.valid || (a.seek < b.seek) ||
			((a.seek == b.seek) && (a.idx < b.idx)));
		return a_wins ? a : b;
	endfunction

endpackage

// ===== rtl/sstf_if.sv =====
// valid/ready channel interfaces for request, response and start track config
// depends on sstf_pkg
interface sstf_req_if;
	logic                          valid;
	logic                          ready;
	logic [sstf_pkg::OP_W-1:0]     opcode;
	logic [sstf_pkg::OUT_TRK_W-1:0] track;

	modport source (output valid, output opcode, output track, input ready);
	modport sink (input valid, input opcode, input track, output ready);
endinterface

interface sstf_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [sstf_pkg::ST_W-1:0]      status;
	logic [sstf_pkg::OUT_TRK_W-1:0] served_track;
	logic [sstf_pkg::OUT_IDX_W-1:0] served_index;
	logic [sstf_pkg::OUT_TRK_W-1:0] seek_distance;
	logic [sstf_pkg::SUM_W-1:0]     total_distance;

	modport source (output valid, output status, output served_track, output served_index,
		output seek_distance, output total_distance, input ready);
	modport sink (input valid, input status, input served_track, input served_index,
		input seek_distance, input total_distance, output ready);
endinterface

interface sstf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sstf_pkg::OUT_TRK_W-1:0] start_track;

	modport source (output valid, output start_track, input ready);
	modport sink (input valid, input start_track, output ready);
endinterface

// ===== rtl/sstf_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module sstf_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/sstf_cell.sv =====
// one scan cell: a bank of the request table, a local nearest-request tracker
// and a chain stage that merges its best with the upstream neighbor; uses sstf_pkg, sstf_ram
module sstf_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [sstf_pkg::CELL_W-1:0]     cell_id,
	input  sstf_pkg::scan_ctrl_t            ctrl,
	input  sstf_pkg::wr_req_t               wr,
	input  logic [sstf_pkg::CNT_W-1:0]      count,
	input  logic [sstf_pkg::TRACK_BITS-1:0] head,
	input  sstf_pkg::best_t                 chain_in,
	output sstf_pkg::best_t                 chain_out
);

	logic                         scan_s1;
	logic [sstf_pkg::ROW_W-1:0]   row_s1;
	logic [sstf_pkg::ENTRY_W-1:0] rd_data;
	sstf_pkg::entry_t             entry_s1;
	logic [sstf_pkg::IDX_W-1:0]   idx_c;
	sstf_pkg::best_t              cand_c;
	sstf_pkg::best_t              cand_s2;
	sstf_pkg::best_t              local_q;
	sstf_pkg::best_t              chain_q;

	sstf_ram #(
		.WIDTH (sstf_pkg::ENTRY_W),
		.DEPTH (sstf_pkg::BANK_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr.en && (wr.bank == cell_id)),
		.wr_addr (wr.row),
		.wr_data (wr.entry),
		.rd_en   (ctrl.scan),
		.rd_addr (ctrl.row),
		.rd_data (rd_data)
	);

	assign entry_s1 = sstf_pkg::entry_t'(rd_data);
	assign idx_c    = {row_s1, cell_id};

	// entries at or past the fill count hold nothing
	always_comb begin
		cand_c.valid = scan_s1 &&
			(sstf_pkg::CMP_W'(idx_c) < sstf_pkg::CMP_W'(count)) && !entry_s1.served;
		cand_c.seek  = sstf_pkg::seek_dist(entry_s1.track, head);
		cand_c.idx   = idx_c;
		cand_c.track = entry_s1.track;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
			row_s1  <= '0;
			cand_s2 <= '0;
			local_q <= '0;
			chain_q <= '0;
		end else begin
			scan_s1 <= ctrl.scan;
			row_s1  <= ctrl.row;
			cand_s2 <= cand_c;
			if (ctrl.clear_best) begin
				local_q <= '0;
			end else begin
				local_q <= sstf_pkg::pick_best(cand_s2, local_q);
			end
			chain_q <= sstf_pkg::pick_best(local_q, chain_in);
		end
	end

	assign chain_out = chain_q;

endmodule

// ===== rtl/sstf_disk_scheduler.sv =====
// shortest-seek-time-first scheduler top level: control fsm, head/total state,
// response register and the row of scan cells; uses sstf_pkg, sstf_if, sstf_cell
// load, clear and unused opcodes finish in idle; a full-table load answers ST_FULL through the done state
// serve: the response follows the bank sweep (scan state) and the chain merge (drain state);
// next request taken back in idle, even if rsp waits
// reset empties the table, head, total and start track go to zero; no clearing pass
module sstf_disk_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	sstf_req_if.sink    req,
	sstf_rsp_if.source  rsp,
	sstf_cfg_if.sink    cfg
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [sstf_pkg::ROW_W-1:0]      row_q;
	logic [sstf_pkg::DRN_W-1:0]      drain_q;
	logic [sstf_pkg::CNT_W-1:0]      count_q;
	logic [sstf_pkg::TRACK_BITS-1:0] head_q;
	logic [sstf_pkg::SUM_W-1:0]      sum_q;
	logic [sstf_pkg::TRACK_BITS-1:0] start_q;
	logic                            full_q;

	logic                            rsp_valid_q;
	logic [sstf_pkg::ST_W-1:0]       rsp_status_q;
	logic [sstf_pkg::OUT_TRK_W-1:0]  rsp_track_q;
	logic [sstf_pkg::OUT_IDX_W-1:0]  rsp_index_q;
	logic [sstf_pkg::OUT_TRK_W-1:0]  rsp_dist_q;
	logic [sstf_pkg::SUM_W-1:0]      rsp_total_q;

	logic                            req_fire;
	logic                            is_load;
	logic                            is_serve;
	logic                            is_clear;
	logic                            table_full;
	logic                            rsp_free;
	logic                            done_go;
	logic [sstf_pkg::IDX_W-1:0]      load_idx;
	logic [sstf_pkg::SUM_W:0]        sum_add;
	logic [sstf_pkg::SUM_W-1:0]      sum_next;
	sstf_pkg::scan_ctrl_t            ctrl;
	sstf_pkg::wr_req_t               wr;
	sstf_pkg::best_t                 chain [sstf_pkg::CELLS+1];
	sstf_pkg::best_t                 final_best;

	assign req.ready  = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign req_fire   = req.valid && req.ready;
	assign is_load    = (req.opcode == sstf_pkg::OP_LOAD);
	assign is_serve   = (req.opcode == sstf_pkg::OP_SERVE);
	assign is_clear   = (req.opcode == sstf_pkg::OP_CLEAR);
	assign table_full = (count_q == sstf_pkg::CNT_W'(sstf_pkg::MAX_REQUESTS));
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign done_go    = (state_q == S_DONE) && rsp_free;
	assign load_idx   = sstf_pkg::IDX_W'(count_q);
	assign final_best = chain[sstf_pkg::CELLS];

	assign sum_add  = (sstf_pkg::SUM_W+1)'(sum_q) + (sstf_pkg::SUM_W+1)'(final_best.seek);
	assign sum_next = sum_add[sstf_pkg::SUM_W] ? sstf_pkg::SUM_MAX : sum_add[sstf_pkg::SUM_W-1:0];

	always_comb begin
		ctrl.scan       = (state_q == S_SCAN);
		ctrl.clear_best = req_fire && is_serve;
		ctrl.row        = row_q;
	end

	// one write port: new request on load, served mark at the end of a serve
	always_comb begin
		wr.en          = 1'b0;
		wr.bank        = load_idx[sstf_pkg::CELL_W-1:0];
		wr.row         = load_idx[sstf_pkg::IDX_W-1:sstf_pkg::CELL_W];
		wr.entry.served = 1'b0;
		wr.entry.track = sstf_pkg::TRACK_BITS'(req.track);
		if (done_go) begin
			wr.en           = !full_q && final_best.valid;
			wr.bank         = final_best.idx[sstf_pkg::CELL_W-1:0];
			wr.row          = final_best.idx[sstf_pkg::IDX_W-1:sstf_pkg::CELL_W];
			wr.entry.served = 1'b1;
			wr.entry.track  = final_best.track;
		end else if (req_fire && is_load && !table_full) begin
			wr.en = 1'b1;
		end
	end

	assign chain[0] = '0;

	for (genvar k = 0; k < sstf_pkg::CELLS; k++) begin : g_cell
		sstf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_id   (sstf_pkg::CELL_W'(k)),
			.ctrl      (ctrl),
			.wr        (wr),
			.count     (count_q),
			.head      (head_q),
			.chain_in  (chain[k]),
			.chain_out (chain[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			drain_q     <= '0;
			count_q     <= '0;
			head_q      <= '0;
			sum_q       <= '0;
			start_q     <= '0;
			full_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				start_q <= sstf_pkg::TRACK_BITS'(cfg.start_track);
			end
			if (done_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (is_load) begin
							if (table_full) begin
								full_q  <= 1'b1;
								state_q <= S_DONE;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end else if (is_serve) begin
							full_q  <= 1'b0;
							row_q   <= '0;
							state_q <= S_SCAN;
						end else if (is_clear) begin
							count_q <= '0;
							head_q  <= start_q;
							sum_q   <= '0;
						end
					end
				end
				S_SCAN: begin
					row_q <= row_q + 1'b1;
					if (row_q == sstf_pkg::ROW_W'(sstf_pkg::BANK_DEPTH - 1)) begin
						drain_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == sstf_pkg::DRN_W'(sstf_pkg::DRAIN_CYCLES - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
						if (!full_q && final_best.valid) begin
							head_q <= final_best.track;
							sum_q  <= sum_next;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			rsp_total_q <= sum_q;
			rsp_track_q <= '0;
			rsp_index_q <= '0;
			rsp_dist_q  <= '0;
			if (full_q) begin
				rsp_status_q <= sstf_pkg::ST_FULL;
			end else if (final_best.valid) begin
				rsp_status_q <= sstf_pkg::ST_SERVED;
				rsp_track_q  <= sstf_pkg::OUT_TRK_W'(final_best.track);
				rsp_index_q  <= sstf_pkg::OUT_IDX_W'(final_best.idx);
				rsp_dist_q   <= sstf_pkg::OUT_TRK_W'(final_best.seek);
				rsp_total_q  <= sum_next;
			end else begin
				rsp_status_q <= sstf_pkg::ST_EMPTY;
				rsp_track_q  <= sstf_pkg::OUT_TRK_W'(head_q);
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.served_track   = rsp_track_q;
	assign rsp.served_index   = rsp_index_q;
	assign rsp.seek_distance  = rsp_dist_q;
	assign rsp.total_distance = rsp_total_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sstf_pkg::CNT_W'(sstf_pkg::MAX_REQUESTS))
		else $error("request count past table size");

	a_done_hands_off: assert property (@(posedge clk) disable iff (!arst_n)
		done_go |=> (rsp.valid && state_q == S_IDLE))
		else $error("finished request did not reach the response register");

	a_dist_in_total: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == sstf_pkg::ST_SERVED) |->
		(rsp.seek_distance <= rsp.total_distance))
		else $error("seek distance exceeds running total");

endmodule

// ===== test/sstf_disk_scheduler_tb.sv =====
// self-checking testbench for the sstf disk scheduler: directed table, then random phases
// with random idling on request and response sides, checked against an in-bench predictor
// depends on sstf_pkg, sstf_if and the sstf_disk_scheduler rtl
`timescale 1ns / 1ps

module sstf_disk_scheduler_tb;

	localparam logic [sstf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SERVE_LAT = sstf_pkg::BANK_DEPTH + sstf_pkg::DRAIN_CYCLES + 1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TOTAL_ITEMS = 580;

	typedef struct packed {
		sstf_pkg::status_t                status;
		logic [sstf_pkg::OUT_TRK_W-1:0]   trk;
		logic [sstf_pkg::OUT_IDX_W-1:0]   idx;
		logic [sstf_pkg::OUT_TRK_W-1:0]   seek;
		logic [sstf_pkg::SUM_W-1:0]       total;
	} answer_t;

	typedef struct packed {
		logic [sstf_pkg::OP_W-1:0]      op;
		logic [sstf_pkg::OUT_TRK_W-1:0] trk;
		logic                           typed;
		answer_t                        ans;
	} plan_row_t;

	localparam answer_t NO_ANS = '0;

	localparam plan_row_t PLAN [0:22] = '{
		'{sstf_pkg::OP_SERVE, 12'd4095, 1'b1,
			'{sstf_pkg::ST_EMPTY,  12'd0,    10'd0, 12'd0,    22'd0}},
		'{sstf_pkg::OP_LOAD,  12'd4095, 1'b0, NO_ANS},
		'{sstf_pkg::OP_LOAD,  12'd0,    1'b0, NO_ANS},
		'{sstf_pkg::OP_SERVE, 12'd0,    1'b1,
			'{sstf_pkg::ST_SERVED, 12'd0,    10'd1, 12'd0,    22'd0}},
		'{sstf_pkg::OP_SERVE, 12'd2730, 1'b1,
			'{sstf_pkg::ST_SERVED, 12'd4095, 10'd0, 12'd4095, 22'd4095}},
		'{sstf_pkg::OP_SERVE, 12'd1365, 1'b1,
			'{sstf_pkg::ST_EMPTY,  12'd4095, 10'd0, 12'd0,    22'd4095}},
		'{OP_UNUSED,          12'd4095, 1'b0, NO_ANS},
		'{sstf_pkg::OP_CLEAR, 12'd4095, 1'b0, NO_ANS},
		'{sstf_pkg::OP_SERVE, 12'd0,    1'b1,
			'{sstf_pkg::ST_EMPTY,  12'd150,  10'd0, 12'd0,    22'd0}},
		'{sstf_pkg::OP_LOAD,  12'd100,  1'b0, NO_ANS},
		'{sstf_pkg::OP_LOAD,  12'd200,  1'b0, NO_ANS},
		'{sstf_pkg::OP_LOAD,  12'd200,  1'b0, NO_ANS},
		'{sstf_pkg::OP_SERVE, 12'd0,    1'b1,
			'{sstf_pkg::ST_SERVED, 12'd100,  10'd0, 12'd50,   22'd50}},
		'{sstf_pkg::OP_SERVE, 12'd0,    1'b1,
			'{sstf_pkg::ST_SERVED, 12'd200,  10'd1, 12'd100,  22'd150}},
		'{sstf_pkg::OP_SERVE, 12'd0,    1'b1,
			'{sstf_pkg::ST_SERVED, 12'd200,  10'd2, 12'd0,    22'd150}},
		'{sstf_pkg::OP_SERVE, 12'd0,    1'b1,
			'{sstf_pkg::ST_EMPTY,  12'd200,  10'd0, 12'd0,    22'd150}},
		'{sstf_pkg::OP_LOAD,  12'd2730, 1'b0, NO_ANS},
		'{sstf_pkg::OP_LOAD,  12'd1365, 1'b0, NO_ANS},
		'{sstf_pkg::OP_LOAD,  12'd4095, 1'b0, NO_ANS},
		'{sstf_pkg::OP_SERVE, 12'd4095, 1'b0, NO_ANS},
		'{sstf_pkg::OP_SERVE, 12'd0,    1'b0, NO_ANS},
		'{sstf_pkg::OP_SERVE, 12'd2730, 1'b0, NO_ANS},
		'{sstf_pkg::OP_CLEAR, 12'd0,    1'b0, NO_ANS}
	};

	logic clk;
	logic arst_n;

	sstf_req_if req_ch ();
	sstf_rsp_if rsp_ch ();
	sstf_cfg_if cfg_ch ();

	sstf_disk_scheduler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// scheduler state as predicted
	logic [sstf_pkg::OUT_TRK_W-1:0]  tbl_track [sstf_pkg::MAX_REQUESTS];
	bit [sstf_pkg::MAX_REQUESTS-1:0] tbl_done;
	int                              req_count;
	logic [sstf_pkg::OUT_TRK_W-1:0]  head_trk;
	int                              dist_sum;
	logic [sstf_pkg::OUT_TRK_W-1:0]  start_trk;

	answer_t answers_due [$];
	int      bad_count = 0;
	int      cycles = 0;
	int      sent_items = 0;
	int      req_gap;
	bit      req_quiet;
	bit      rsp_quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sstf_disk_scheduler test failed");
			$finish;
		end
	end

	task automatic schedule_request(input logic [sstf_pkg::OP_W-1:0] op,
		input logic [sstf_pkg::OUT_TRK_W-1:0] trk, output bit got, output answer_t a);
		int best;
		logic [sstf_pkg::OUT_TRK_W-1:0] d;
		logic [sstf_pkg::OUT_TRK_W-1:0] bd;
		logic [sstf_pkg::OUT_TRK_W-1:0] t;
		got = 1'b0;
		a = '0;
		best = -1;
		bd = '0;
		case (op)
			sstf_pkg::OP_LOAD: begin
				if (req_count >= sstf_pkg::MAX_REQUESTS) begin
					got = 1'b1;
					a.status = sstf_pkg::ST_FULL;
					a.total = sstf_pkg::SUM_W'(dist_sum);
				end else begin
					tbl_track[req_count] = trk;
					tbl_done[req_count] = 1'b0;
					req_count++;
				end
			end
			sstf_pkg::OP_SERVE: begin
				for (int i = 0; i < req_count; i++) begin
					if (!tbl_done[i]) begin
						t = tbl_track[i];
						d = (t >= head_trk) ? t - head_trk : head_trk - t;
						if (best < 0 || d < bd) begin
							best = i;
							bd = d;
						end
					end
				end
				got = 1'b1;
				if (best < 0) begin
					a.status = sstf_pkg::ST_EMPTY;
					a.trk = head_trk;
				end else begin
					tbl_done[best] = 1'b1;
					head_trk = tbl_track[best];
					dist_sum += int'(bd);
					if (dist_sum > int'(sstf_pkg::SUM_MAX))
						dist_sum = int'(sstf_pkg::SUM_MAX);
					a.status = sstf_pkg::ST_SERVED;
					a.trk = head_trk;
					a.idx = sstf_pkg::OUT_IDX_W'(best);
					a.seek = bd;
				end
				a.total = sstf_pkg::SUM_W'(dist_sum);
			end
			sstf_pkg::OP_CLEAR: begin
				tbl_done = '0;
				req_count = 0;
				head_trk = start_trk;
				dist_sum = 0;
			end
			default: ;
		endcase
	endtask

	task automatic send_req(input logic [sstf_pkg::OP_W-1:0] op,
		input logic [sstf_pkg::OUT_TRK_W-1:0] trk, input bit typed, input answer_t typed_ans);
		bit got;
		answer_t a;
		if (req_gap > 0)
			repeat (req_gap) @(posedge clk);
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.track  <= trk;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		schedule_request(op, trk, got, a);
		sent_items++;
		if (got)
			answers_due.push_back(typed ? typed_ans : a);
		req_gap = req_quiet ? 0 : $urandom_range(0, 15);
		if (req_gap > 0)
			req_ch.valid <= 1'b0;
	endtask

	task automatic write_start(input logic [sstf_pkg::OUT_TRK_W-1:0] v);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.start_track <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		start_trk = v;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		if (req_gap == 0) begin
			req_ch.valid <= 1'b0;
			req_gap = 1;
		end
		while (answers_due.size() != 0) @(posedge clk);
		repeat (SERVE_LAT + 16) @(posedge clk);
	endtask

	function automatic logic [sstf_pkg::OUT_TRK_W-1:0] pick_track(int style,
		logic [sstf_pkg::OUT_TRK_W-1:0] base);
		case (style)
			0: return sstf_pkg::OUT_TRK_W'($urandom_range(0, 4095));
			1: return $urandom_range(0, 1) ? sstf_pkg::OUT_TRK_W'(4095 - $urandom_range(0, 3))
				: sstf_pkg::OUT_TRK_W'($urandom_range(0, 3));
			default: return base + sstf_pkg::OUT_TRK_W'($urandom_range(0, 16))
				- sstf_pkg::OUT_TRK_W'(8);
		endcase
	endfunction

	task automatic check_answer();
		answer_t want;
		answer_t got;
		got = '{sstf_pkg::status_t'(rsp_ch.status), rsp_ch.served_track, rsp_ch.served_index,
			rsp_ch.seek_distance, rsp_ch.total_distance};
		if (answers_due.size() == 0) begin
			bad_count++;
			if (bad_count <= 10)
				$display("unexpected response: status %0d track %0d index %0d seek %0d total %0d",
					got.status, got.trk, got.idx, got.seek, got.total);
		end else begin
			want = answers_due.pop_front();
			if (got !== want) begin
				bad_count++;
				if (bad_count <= 10)
					$display({"mismatch: expected status %0d track %0d index %0d seek %0d ",
						"total %0d, got status %0d track %0d index %0d seek %0d total %0d"},
						want.status, want.trk, want.idx, want.seek, want.total,
						got.status, got.trk, got.idx, got.seek, got.total);
			end
		end
	endtask

	// response side: random stall before each response, none while rsp_quiet is set
	initial begin
		int stall;
		forever begin
			stall = rsp_quiet ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			check_answer();
			if ($urandom_range(0, 31) == 0)
				rsp_quiet = !rsp_quiet;
		end
	end

	initial begin
		int phase;
		int n;
		int style;
		logic [sstf_pkg::OUT_TRK_W-1:0] base;
		logic [sstf_pkg::OP_W-1:0] op;
		phase = 0;
		req_gap = 1;
		req_quiet = 1'b0;
		req_count = 0;
		tbl_done = '0;
		head_trk = '0;
		dist_sum = 0;
		start_trk = '0;
		req_ch.valid       <= 1'b0;
		req_ch.opcode      <= sstf_pkg::OP_LOAD;
		req_ch.track       <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.start_track <= '0;
		arst_n             <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		write_start(12'd150);

		for (int i = 0; i < $size(PLAN); i++)
			send_req(PLAN[i].op, PLAN[i].trk, PLAN[i].typed, PLAN[i].ans);

		while (sent_items < TOTAL_ITEMS) begin
			settle();
			case (phase)
				0: write_start(12'd0);
				1: write_start(12'd4095);
				default: write_start(sstf_pkg::OUT_TRK_W'($urandom_range(0, 4095)));
			endcase
			req_quiet = ($urandom_range(0, 3) == 0);
			send_req(sstf_pkg::OP_CLEAR, sstf_pkg::OUT_TRK_W'($urandom_range(0, 4095)),
				1'b0, NO_ANS);
			repeat ($urandom_range(3, 6)) begin
				style = $urandom_range(0, 2);
				base = sstf_pkg::OUT_TRK_W'($urandom_range(0, 4095));
				n = $urandom_range(1, 10);
				repeat (n)
					send_req(sstf_pkg::OP_LOAD, pick_track(style, base), 1'b0, NO_ANS);
				repeat (n + $urandom_range(0, 2)) begin
					if ($urandom_range(0, 7) == 0) begin
						op = sstf_pkg::OP_W'($urandom_range(0, 3));
						send_req(op, pick_track(style, base), 1'b0, NO_ANS);
					end
					send_req(sstf_pkg::OP_SERVE, sstf_pkg::OUT_TRK_W'($urandom_range(0, 4095)),
						1'b0, NO_ANS);
				end
				if ($urandom_range(0, 9) == 0)
					send_req(sstf_pkg::OP_CLEAR,
						sstf_pkg::OUT_TRK_W'($urandom_range(0, 4095)), 1'b0, NO_ANS);
			end
			phase++;
		end

		settle();
		if (bad_count == 0)
			$display("sstf_disk_scheduler test passed");
		else
			$display("sstf_disk_scheduler test failed");
		$finish;
	end

endmodule

// ===== sstf_disk_scheduler.f =====
rtl/sstf_pkg.sv
rtl/sstf_if.sv
rtl/sstf_ram.sv
rtl/sstf_cell.sv
rtl/sstf_disk_scheduler.sv
test/sstf_disk_scheduler_tb.sv
